[hw/rtl/cxa_pkg.sv]
// ----------------------------------------------------------------------------
// cxa_pkg
// types, command codes and clamp helpers for the complex accumulator alu
// ----------------------------------------------------------------------------
package cxa_pkg;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] operand_real;
      logic signed [31:0] operand_imag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_real;
      logic signed [31:0] result_imag;
      logic               divide_by_zero;
      logic               saturated;
   } rsp_type;

   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_ADD   = 3'd1;
   localparam logic [2:0] CMD_SUB   = 3'd2;
   localparam logic [2:0] CMD_MUL   = 3'd3;
   localparam logic [2:0] CMD_DIV   = 3'd4;
   localparam logic [2:0] CMD_ADDS  = 3'd5;
   localparam logic [2:0] CMD_SCALE = 3'd6;
   localparam logic [2:0] CMD_DIVS  = 3'd7;

   localparam logic signed [65:0] MAX_POS66 = 66'sh0_7fff_ffff;
   localparam logic signed [65:0] MAX_NEG66 = -66'sh0_8000_0000;

   // {saturated, value} of a wide signed value clamped to 32 bits
   function automatic logic [32:0] clamp_wide(logic signed [65:0] v);
      logic [32:0] r;
      if (v > MAX_POS66) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (v < MAX_NEG66) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // {saturated, value} of a sign and a quotient magnitude with overflow mark
   function automatic logic [32:0] clamp_quot(logic neg, logic ovf, logic [32:0] q);
      logic [32:0] r;
      if (!neg) begin
         if (ovf || q > 33'h0_7fff_ffff) begin
            r = {1'b1, 32'h7fff_ffff};
         end else begin
            r = {1'b0, q[31:0]};
         end
      end else begin
         if (ovf || q > 33'h0_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
         end else begin
            r = {1'b0, 32'd0 - q[31:0]};
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/complex_accumulator_alu_top.sv]
// ----------------------------------------------------------------------------
// complex_accumulator_alu_top
// complex accumulator in signed fixed point with bit-serial multiply and divide
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_data  (req_type)
//  rsp       out        rsp_valid/rsp_stall   rsp_data  (rsp_type)
//
//  load, add, subtract and add-real finish in the cycle of the transfer.
//  multiply and scale take one multiplier bit per cycle. complex divide runs
//  the multiplier, then the divider; divide by real runs the divider alone:
//  the restoring divider retires one quotient bit per cycle in each lane.
//  reset clears the accumulator to zero and empties the result register.
//  one item is in work at a time; a held result blocks the finishing step.
// ----------------------------------------------------------------------------
module complex_accumulator_alu_top
   import cxa_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // dividend width: 64-bit magnitude followed by the fraction bits
   localparam int NW = 64 + FRAC_BITS;
   localparam int CW = $clog2(NW);
   localparam logic [CW-1:0] MUL_LAST = CW'(31);
   localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0] cmd_ff, cmd_in;
   logic signed [31:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // multiplier: shifted multiplicands, multiplier bits, partial sums
   logic signed [63:0] mca_ff, mca_in, mcb_ff, mcb_in, mcc_ff, mcc_in, mcd_ff, mcd_in;
   logic [31:0] mpc_ff, mpc_in, mpd_ff, mpd_in;
   logic signed [65:0] pr_ff, pr_in, pi_ff, pi_in, pd_ff, pd_in;

   // divider: two lanes sharing one divisor
   logic [NW-1:0] dvr_ff, dvr_in, dvi_ff, dvi_in;
   logic [63:0] remr_ff, remr_in, remi_ff, remi_in, den_ff, den_in;
   logic [32:0] qr_ff, qr_in, qi_ff, qi_in;
   logic ovr_ff, ovr_in, ovi_ff, ovi_in, negr_ff, negr_in, negi_ff, negi_in;

   logic req_go, out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_go    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one multiplier step; the sign bit of the multiplier weighs negative
   logic signed [65:0] t_ac, t_bd, t_ad, t_bc, t_cc, t_dd, s_r, s_i, s_d;
   logic signed [65:0] pr_nx, pi_nx, pd_nx;
   logic is_div, mul_last;
   assign is_div   = (cmd_ff == CMD_DIV);
   assign mul_last = (cnt_ff == MUL_LAST);
   assign t_ac = mpc_ff[0] ? {{2{mca_ff[63]}}, mca_ff} : '0;
   assign t_bc = mpc_ff[0] ? {{2{mcb_ff[63]}}, mcb_ff} : '0;
   assign t_cc = mpc_ff[0] ? {{2{mcc_ff[63]}}, mcc_ff} : '0;
   assign t_ad = mpd_ff[0] ? {{2{mca_ff[63]}}, mca_ff} : '0;
   assign t_bd = mpd_ff[0] ? {{2{mcb_ff[63]}}, mcb_ff} : '0;
   assign t_dd = mpd_ff[0] ? {{2{mcd_ff[63]}}, mcd_ff} : '0;
   // multiply: ac - bd, ad + bc; divide numerators: ac + bd, bc - ad
   assign s_r = is_div ? (t_ac + t_bd) : (t_ac - t_bd);
   assign s_i = is_div ? (t_bc - t_ad) : (t_bc + t_ad);
   assign s_d = t_cc + t_dd;
   assign pr_nx = mul_last ? (pr_ff - s_r) : (pr_ff + s_r);
   assign pi_nx = mul_last ? (pi_ff - s_i) : (pi_ff + s_i);
   assign pd_nx = mul_last ? (pd_ff - s_d) : (pd_ff + s_d);

   // restoring division step, one quotient bit per lane
   logic [64:0] r2r, r2i;
   logic ger, gei;
   logic [32:0] qr_nx, qi_nx;
   assign r2r = {remr_ff, dvr_ff[NW-1]};
   assign r2i = {remi_ff, dvi_ff[NW-1]};
   assign ger = r2r >= {1'b0, den_ff};
   assign gei = r2i >= {1'b0, den_ff};
   assign qr_nx = {qr_ff[31:0], ger};
   assign qi_nx = {qi_ff[31:0], gei};

   // operand views for the accepted transfer
   logic signed [32:0] add_r, add_i, sub_r, sub_i;
   logic [32:0] cl_ar, cl_ai, cl_sr, cl_si;
   assign add_r = {acc_re_ff[31], acc_re_ff} + {req_data.operand_real[31], req_data.operand_real};
   assign add_i = {acc_im_ff[31], acc_im_ff} + {req_data.operand_imag[31], req_data.operand_imag};
   assign sub_r = {acc_re_ff[31], acc_re_ff} - {req_data.operand_real[31], req_data.operand_real};
   assign sub_i = {acc_im_ff[31], acc_im_ff} - {req_data.operand_imag[31], req_data.operand_imag};
   assign cl_ar = clamp_wide({{33{add_r[32]}}, add_r});
   assign cl_ai = clamp_wide({{33{add_i[32]}}, add_i});
   assign cl_sr = clamp_wide({{33{sub_r[32]}}, sub_r});
   assign cl_si = clamp_wide({{33{sub_i[32]}}, sub_i});

   // magnitudes for divide by real
   logic [31:0] mag_c, mag_a, mag_b;
   assign mag_c = req_data.operand_real[31] ? 32'd0 - req_data.operand_real
                                            : req_data.operand_real;
   assign mag_a = acc_re_ff[31] ? 32'd0 - acc_re_ff : acc_re_ff;
   assign mag_b = acc_im_ff[31] ? 32'd0 - acc_im_ff : acc_im_ff;

   // end of multiply: floor shift for products, sign/magnitude for division
   logic signed [65:0] sh_r, sh_i;
   logic [32:0] cl_mr, cl_mi, cl_qr, cl_qi;
   logic [63:0] mgr, mgi;
   assign sh_r  = pr_nx >>> FRAC_BITS;
   assign sh_i  = pi_nx >>> FRAC_BITS;
   assign cl_mr = clamp_wide(sh_r);
   assign cl_mi = clamp_wide(sh_i);
   assign mgr   = pr_nx[65] ? 64'd0 - pr_nx[63:0] : pr_nx[63:0];
   assign mgi   = pi_nx[65] ? 64'd0 - pi_nx[63:0] : pi_nx[63:0];
   assign cl_qr = clamp_quot(negr_ff, ovr_ff | qr_ff[32], qr_nx);
   assign cl_qi = clamp_quot(negi_ff, ovi_ff | qi_ff[32], qi_nx);

   always_comb begin
      state_in = state_ff;   cnt_in = cnt_ff;       cmd_in = cmd_ff;
      acc_re_in = acc_re_ff; acc_im_in = acc_im_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      mca_in = mca_ff; mcb_in = mcb_ff; mcc_in = mcc_ff; mcd_in = mcd_ff;
      mpc_in = mpc_ff; mpd_in = mpd_ff;
      pr_in = pr_ff; pi_in = pi_ff; pd_in = pd_ff;
      dvr_in = dvr_ff; dvi_in = dvi_ff; remr_in = remr_ff; remi_in = remi_ff;
      den_in = den_ff; qr_in = qr_ff; qi_in = qi_ff;
      ovr_in = ovr_ff; ovi_in = ovi_ff; negr_in = negr_ff; negi_in = negi_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               cmd_in = req_data.command;
               rsp_in.divide_by_zero = 1'b0;
               rsp_in.saturated = 1'b0;
               rsp_in.result_real = acc_re_ff;
               rsp_in.result_imag = acc_im_ff;
               // multiplier setup, used by multiply, scale and complex divide
               mca_in = 64'(acc_re_ff);
               mcb_in = 64'(acc_im_ff);
               mcc_in = 64'(req_data.operand_real);
               mcd_in = 64'(req_data.operand_imag);
               mpc_in = req_data.operand_real;
               mpd_in = (req_data.command == CMD_SCALE) ? 32'd0 : req_data.operand_imag;
               pr_in = '0; pi_in = '0; pd_in = '0;
               cnt_in = '0;
               // divider setup, used by divide by real
               den_in = {32'd0, mag_c};
               dvr_in = {32'd0, mag_a, {FRAC_BITS{1'b0}}};
               dvi_in = {32'd0, mag_b, {FRAC_BITS{1'b0}}};
               remr_in = '0; remi_in = '0; qr_in = '0; qi_in = '0;
               ovr_in = 1'b0; ovi_in = 1'b0;
               negr_in = acc_re_ff[31] ^ req_data.operand_real[31];
               negi_in = acc_im_ff[31] ^ req_data.operand_real[31];
               case (req_data.command)
                  CMD_LOAD: begin
                     rsp_in.result_real = req_data.operand_real;
                     rsp_in.result_imag = req_data.operand_imag;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_ADD: begin
                     rsp_in.result_real = cl_ar[31:0];
                     rsp_in.result_imag = cl_ai[31:0];
                     rsp_in.saturated = cl_ar[32] | cl_ai[32];
                     rsp_valid_in = 1'b1;
                  end
                  CMD_SUB: begin
                     rsp_in.result_real = cl_sr[31:0];
                     rsp_in.result_imag = cl_si[31:0];
                     rsp_in.saturated = cl_sr[32] | cl_si[32];
                     rsp_valid_in = 1'b1;
                  end
                  CMD_ADDS: begin
                     rsp_in.result_real = cl_ar[31:0];
                     rsp_in.saturated = cl_ar[32];
                     rsp_valid_in = 1'b1;
                  end
                  CMD_MUL, CMD_SCALE: begin
                     state_in = ST_MUL;
                  end
                  CMD_DIV: begin
                     if (req_data.operand_real == 32'sd0 && req_data.operand_imag == 32'sd0) begin
                        rsp_in.divide_by_zero = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     if (req_data.operand_real == 32'sd0) begin
                        rsp_in.divide_by_zero = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
               endcase
               if (rsp_valid_in && req_data.command != CMD_DIV
                   && req_data.command != CMD_DIVS) begin
                  acc_re_in = rsp_in.result_real;
                  acc_im_in = rsp_in.result_imag;
               end
            end
         end
         ST_MUL: begin
            if (!mul_last || is_div || out_free) begin
               pr_in = pr_nx; pi_in = pi_nx; pd_in = pd_nx;
               mca_in = mca_ff <<< 1; mcb_in = mcb_ff <<< 1;
               mcc_in = mcc_ff <<< 1; mcd_in = mcd_ff <<< 1;
               mpc_in = mpc_ff >> 1;  mpd_in = mpd_ff >> 1;
               cnt_in = cnt_ff + CW'(1);
               if (mul_last) begin
                  cnt_in = '0;
                  if (is_div) begin
                     // numerators and squared magnitude ready: start the divider
                     state_in = ST_DIV;
                     den_in = pd_nx[63:0];
                     negr_in = pr_nx[65];
                     negi_in = pi_nx[65];
                     dvr_in = {mgr, {FRAC_BITS{1'b0}}};
                     dvi_in = {mgi, {FRAC_BITS{1'b0}}};
                  end else begin
                     state_in = ST_IDLE;
                     rsp_in.result_real = cl_mr[31:0];
                     rsp_in.result_imag = cl_mi[31:0];
                     rsp_in.saturated = cl_mr[32] | cl_mi[32];
                     rsp_in.divide_by_zero = 1'b0;
                     rsp_valid_in = 1'b1;
                     acc_re_in = cl_mr[31:0];
                     acc_im_in = cl_mi[31:0];
                  end
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff != DIV_LAST || out_free) begin
               dvr_in = dvr_ff << 1;
               dvi_in = dvi_ff << 1;
               remr_in = ger ? 64'(r2r - {1'b0, den_ff}) : r2r[63:0];
               remi_in = gei ? 64'(r2i - {1'b0, den_ff}) : r2i[63:0];
               qr_in = qr_nx; qi_in = qi_nx;
               ovr_in = ovr_ff | qr_ff[32];
               ovi_in = ovi_ff | qi_ff[32];
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == DIV_LAST) begin
                  cnt_in = '0;
                  state_in = ST_IDLE;
                  rsp_in.result_real = cl_qr[31:0];
                  rsp_in.result_imag = cl_qi[31:0];
                  rsp_in.saturated = cl_qr[32] | cl_qi[32];
                  rsp_in.divide_by_zero = 1'b0;
                  rsp_valid_in = 1'b1;
                  acc_re_in = cl_qr[31:0];
                  acc_im_in = cl_qi[31:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      mca_ff <= mca_in; mcb_ff <= mcb_in; mcc_ff <= mcc_in; mcd_ff <= mcd_in;
      mpc_ff <= mpc_in; mpd_ff <= mpd_in;
      pr_ff <= pr_in; pi_ff <= pi_in; pd_ff <= pd_in;
      dvr_ff <= dvr_in; dvi_ff <= dvi_in;
      remr_ff <= remr_in; remi_ff <= remi_in; den_ff <= den_in;
      qr_ff <= qr_in; qi_ff <= qi_in;
      ovr_ff <= ovr_in; ovi_ff <= ovi_in;
      negr_ff <= negr_in; negi_ff <= negi_in;
   end

endmodule
